// File: rtl/owbm_pkg.sv
// Shared types, codes and constants for the one-wire bus master.
package owbm_pkg;

  localparam int unsigned TICK_W = 11;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 11;

  // Length of the low pulse that opens every read slot.
  localparam logic [TICK_W-1:0] READ_LOW_TICKS = TICK_W'(2);
  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_RESET = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_REC,
    PH_PRES,
    PH_PRES_WAIT,
    PH_WR_LOW,
    PH_WR_HIGH,
    PH_RD_LOW,
    PH_RD_DELAY,
    PH_RD_SAMPLE,
    PH_RD_REC
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_RESET_RECOVER = 3'd1,
    CFG_PRES_TIMEOUT  = 3'd2,
    CFG_PRES_WINDOW   = 3'd3,
    CFG_SLOT_SHORT    = 3'd4,
    CFG_SLOT_LONG     = 3'd5,
    CFG_RD_DELAY      = 3'd6,
    CFG_RD_RECOVER    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [10:0] reset_low;
    logic [9:0]  reset_recover;
    logic [5:0]  pres_timeout;
    logic [9:0]  pres_window;
    logic [9:0]  slot_short;
    logic [9:0]  slot_long;
    logic [9:0]  rd_delay;
    logic [9:0]  rd_recover;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    reset_low:     11'd960,
    reset_recover: 10'd15,
    pres_timeout:  6'd45,
    pres_window:   10'd290,
    slot_short:    10'd5,
    slot_long:     10'd60,
    rd_delay:      10'd8,
    rd_recover:    10'd50
  };

  typedef struct packed {
    action_e     action;
    logic [7:0]  tx_byte;
    logic        line_level;
  } item_t;

  typedef struct packed {
    phase_e             phase;
    logic [TICK_W-1:0]  tick;
    logic [5:0]         pres_cnt;
    logic [2:0]         bit_idx;
    logic [7:0]         shift;
    logic               absent;
    logic [7:0]         rx_last;
  } seq_state_t;

  typedef struct packed {
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  rx_byte;
    logic        no_device;
    logic        rejected;
  } result_t;

endpackage

// File: rtl/owbm_cfg_regs.sv
// Configuration register file of the one-wire bus master.
module owbm_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [owbm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [owbm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output owbm_pkg::cfg_t                    cfg_o
);
  import owbm_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RESET_LOW:     cfg_d.reset_low     = cfg_wdata_i[10:0];
        CFG_RESET_RECOVER: cfg_d.reset_recover = cfg_wdata_i[9:0];
        CFG_PRES_TIMEOUT:  cfg_d.pres_timeout  = cfg_wdata_i[5:0];
        CFG_PRES_WINDOW:   cfg_d.pres_window   = cfg_wdata_i[9:0];
        CFG_SLOT_SHORT:    cfg_d.slot_short    = cfg_wdata_i[9:0];
        CFG_SLOT_LONG:     cfg_d.slot_long     = cfg_wdata_i[9:0];
        CFG_RD_DELAY:      cfg_d.rd_delay      = cfg_wdata_i[9:0];
        CFG_RD_RECOVER:    cfg_d.rd_recover    = cfg_wdata_i[9:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/owbm_seq.sv
// Bus sequencer: phase, tick counter, shift register; one item per cycle with step_i.
module owbm_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  owbm_pkg::cfg_t     cfg_i,
  input  logic               step_i,
  input  owbm_pkg::item_t    item_i,
  output owbm_pkg::result_t  res_o
);
  import owbm_pkg::*;

  seq_state_t st_q;
  seq_state_t st_d;

  function automatic logic is_timed(phase_e p);
    is_timed = (p == PH_RST_LOW) || (p == PH_RST_REC) || (p == PH_PRES_WAIT) ||
               (p == PH_WR_LOW) || (p == PH_WR_HIGH) || (p == PH_RD_LOW) ||
               (p == PH_RD_DELAY) || (p == PH_RD_REC);
  endfunction

  function automatic seq_state_t finish(seq_state_t s);
    seq_state_t r;
    r = s;
    r.phase = PH_IDLE;
    r.tick = '0;
    r.bit_idx = '0;
    return r;
  endfunction

  // Low phase of a write slot: short for a one, long for a zero.
  function automatic logic [TICK_W-1:0] wr_low_len(logic b, cfg_t c);
    wr_low_len = b ? {1'b0, c.slot_short} : {1'b0, c.slot_long};
  endfunction

  function automatic logic [TICK_W-1:0] wr_high_len(logic b, cfg_t c);
    wr_high_len = b ? {1'b0, c.slot_long} : {1'b0, c.slot_short};
  endfunction

  // One phase expiry. When both slot lengths are zero every write bit passes
  // at once, so the whole byte is finished in a single step.
  function automatic seq_state_t expire(seq_state_t s, cfg_t c);
    seq_state_t r;
    logic [7:0] nxt_shift;
    r = s;
    nxt_shift = {1'b0, s.shift[7:1]};
    case (s.phase)
      PH_RST_LOW: begin
        r.phase = PH_RST_REC;
        r.tick = {1'b0, c.reset_recover};
      end
      PH_RST_REC: begin
        r.phase = PH_PRES;
        r.pres_cnt = '0;
        r.tick = '0;
      end
      PH_PRES_WAIT: r = finish(s);
      PH_WR_LOW: begin
        if ((c.slot_short == '0) && (c.slot_long == '0)) begin
          r = finish(s);
        end else begin
          r.phase = PH_WR_HIGH;
          r.tick = wr_high_len(s.shift[0], c);
        end
      end
      PH_WR_HIGH: begin
        r.shift = nxt_shift;
        if (s.bit_idx == LAST_BIT) begin
          r = finish(r);
        end else begin
          r.bit_idx = s.bit_idx + 3'd1;
          r.phase = PH_WR_LOW;
          r.tick = wr_low_len(nxt_shift[0], c);
        end
      end
      PH_RD_LOW: begin
        r.phase = PH_RD_DELAY;
        r.tick = {1'b0, c.rd_delay};
      end
      PH_RD_DELAY: begin
        r.phase = PH_RD_SAMPLE;
        r.tick = '0;
      end
      PH_RD_REC: begin
        if (s.bit_idx == LAST_BIT) begin
          r.rx_last = s.shift;
          r = finish(r);
        end else begin
          r.bit_idx = s.bit_idx + 3'd1;
          r.phase = PH_RD_LOW;
          r.tick = READ_LOW_TICKS;
        end
      end
      default: begin
        r.phase = PH_IDLE;
        r.tick = '0;
      end
    endcase
    return r;
  endfunction

  function automatic seq_state_t settle_step(seq_state_t s, cfg_t c);
    if (is_timed(s.phase) && (s.tick == '0)) begin
      return expire(s, c);
    end
    return s;
  endfunction

  function automatic seq_state_t do_tick(seq_state_t s, cfg_t c, logic line);
    seq_state_t r;
    logic [9:0] cnt_ext;
    r = s;
    cnt_ext = {4'b0, s.pres_cnt};
    if (is_timed(s.phase)) begin
      if (s.tick != '0) begin
        r.tick = s.tick - TICK_W'(1);
      end
    end else if (s.phase == PH_PRES) begin
      if (line) begin
        if (s.pres_cnt >= c.pres_timeout) begin
          r.absent = 1'b1;
          r = finish(r);
        end else begin
          r.pres_cnt = s.pres_cnt + 6'd1;
        end
      end else begin
        r.absent = 1'b0;
        r.phase = PH_PRES_WAIT;
        r.tick = (c.pres_window > cnt_ext) ? {1'b0, c.pres_window - cnt_ext} : '0;
      end
    end else if (s.phase == PH_RD_SAMPLE) begin
      r.shift = {line, s.shift[7:1]};
      r.phase = PH_RD_REC;
      r.tick = {1'b0, c.rd_recover};
    end
    return r;
  endfunction

  seq_state_t pre;
  seq_state_t mid;
  seq_state_t mid2;
  logic       rejected;

  // No chain of zero-length phases needs more than three expiries: with one
  // slot length at zero, a write slot can end, pass an empty high phase and
  // then an empty low phase of the next bit in the same tick.
  always_comb begin
    pre = st_q;
    rejected = 1'b0;
    if ((item_i.action == ACT_TICK) || (st_q.phase != PH_IDLE)) begin
      rejected = (item_i.action != ACT_TICK);
      pre = do_tick(st_q, cfg_i, item_i.line_level);
    end else begin
      case (item_i.action)
        ACT_RESET: begin
          pre.phase = PH_RST_LOW;
          pre.tick = cfg_i.reset_low;
          pre.pres_cnt = '0;
        end
        ACT_WRITE: begin
          pre.shift = item_i.tx_byte;
          pre.bit_idx = '0;
          pre.phase = PH_WR_LOW;
          pre.tick = wr_low_len(item_i.tx_byte[0], cfg_i);
        end
        default: begin
          pre.shift = '0;
          pre.bit_idx = '0;
          pre.phase = PH_RD_LOW;
          pre.tick = READ_LOW_TICKS;
        end
      endcase
    end
    mid = settle_step(pre, cfg_i);
    mid2 = settle_step(mid, cfg_i);
    st_d = settle_step(mid2, cfg_i);

    res_o.drive_low = (st_d.phase == PH_RST_LOW) || (st_d.phase == PH_WR_LOW) ||
                      (st_d.phase == PH_RD_LOW);
    res_o.busy_res  = (st_d.phase != PH_IDLE);
    res_o.done_res  = (st_d.phase == PH_IDLE) &&
                      ((st_q.phase != PH_IDLE) || (item_i.action != ACT_TICK));
    res_o.rx_byte   = st_d.rx_last;
    res_o.no_device = st_d.absent;
    res_o.rejected  = rejected;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_IDLE, tick: '0, pres_cnt: '0, bit_idx: '0,
                shift: '0, absent: 1'b0, rx_last: '0};
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule

// File: rtl/one_wire_bus_master.sv
// Top level of the one-wire bus master: input register, sequencer, result register.
//
// Items arrive on the s_axis channel: tuser carries the action (tick, bus
// reset, write byte, read byte), tdata the byte to send and the sampled line
// level. Each accepted transaction gives exactly one result transaction on
// m_axis with the line drive, busy, done, last read byte, no-device and
// rejected flags. The caller sends one tick item per microsecond and drives
// the bus from drive_low.
// An item passes the input register, then the sequencer into the result register.
// Throughput is one item per cycle while m_axis_tready does not stall the output;
// the sequencer updates its phase and counters in a single pass, with at most
// three back-to-back phase expiries. The configuration port writes one
// register per cycle with cfg_we_i; the user must use it only while the block
// is idle, which the block itself does not enforce. Reset returns the
// configuration registers to their defaults, the sequencer to idle with the
// line released, and the last read byte and no-device flag to zero.
// When m_axis_tready is low the result register holds, the input register
// takes one more item, and s_axis_tready then falls until the result leaves.
module one_wire_bus_master (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,  // tx_byte[7:0], line_level[8]
  input  logic [1:0]                       s_axis_tuser,  // action[1:0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // drive_low[0], busy_res[1], done_res[2], rx_byte[10:3], no_device[11],
  // rejected[12]
  output logic [15:0]                      m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [owbm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [owbm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import owbm_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_vld_q;
  result_t res;
  result_t res_q;
  logic    out_vld_q;
  logic    advance;
  logic    in_load;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  owbm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  owbm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .item_i (item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_load) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      item_q.action     <= action_e'(s_axis_tuser);
      item_q.tx_byte    <= s_axis_tdata[7:0];
      item_q.line_level <= s_axis_tdata[8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, res_q.rejected, res_q.no_device, res_q.rx_byte,
                          res_q.done_res, res_q.busy_res, res_q.drive_low};

endmodule
